[hw/rtl/lbmc_pkg.sv]
// Shared types and constants for the log block merge classifier.
package lbmc_pkg;

    // Widths of the logical page number and of the page index.
    localparam int LPN_BITS      = 32;
    localparam int MAX_PAGE_BITS = 10;
    localparam int PB_W          = 4;
    localparam int GS_W          = 11;
    localparam int GID_W         = 16;
    localparam int CNT_W         = MAX_PAGE_BITS + 1;
    localparam int PROD_W        = GID_W + GS_W;
    localparam int CFG_DATA_W    = 11;

    // Reset values of the configuration registers.
    localparam logic [PB_W-1:0] PAGE_BITS_RESET  = PB_W'(6);
    localparam logic [GS_W-1:0] GROUP_SIZE_RESET = GS_W'(4);

    // Page state codes.
    typedef enum logic [1:0] {
        PS_EMPTY    = 2'd0,
        PS_LIVE     = 2'd1,
        PS_STALE    = 2'd2,
        PS_RESERVED = 2'd3
    } page_state_t;

    // Merge decision codes.
    typedef enum logic [2:0] {
        KIND_ERASE   = 3'd0,
        KIND_SWITCH  = 3'd1,
        KIND_REORDER = 3'd2,
        KIND_PARTIAL = 3'd3,
        KIND_FULL    = 3'd4
    } merge_kind_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_PAGE_BITS  = 1'b0,
        REG_GROUP_SIZE = 1'b1
    } cfg_reg_t;

    // One page descriptor word.
    typedef struct packed {
        logic [1:0]          page_state;
        logic                lpn_present;
        logic [LPN_BITS-1:0] page_lpn;
        logic [GID_W-1:0]    group_id;
    } page_word_t;

    // One merge decision word.
    typedef struct packed {
        merge_kind_t         merge_kind;
        logic [LPN_BITS-1:0] merge_lblock;
        logic [CNT_W-1:0]    valid_pages;
        logic [CNT_W-1:0]    prefix_pages;
    } merge_word_t;

    // Per-page control from the top level to the page tracker.
    typedef struct packed {
        logic                 advance;
        logic [PB_W-1:0]      page_bits;
        logic [GS_W-1:0]      group_size;
    } track_ctrl_t;

endpackage

[hw/rtl/log_block_merge_classifier_unit.sv]
// Top level of the log block merge classifier: configuration, handshakes, result register.
//
//  channel   direction  handshake                    word
//  item      in         item_valid / item_ready      page_word_t, one per page
//  result    out        result_valid / result_ready  merge_word_t, one per block
//  cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Page words are taken back to back while item_ready is high. A block holds 2^page_bits
// pages, page_bits clamped into 1..10. The decision is formed with the last page, held in
// the result register, and appears in the cycle after that page is accepted.
// Reset returns page_bits to 6, group_size to 4 and clears the block state.
// Page words keep flowing while a decision waits; only the last page of the next block
// is held off until the waiting decision is taken. Configuration writes are always taken.
module log_block_merge_classifier_unit
    import lbmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  page_word_t            item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output merge_word_t           result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PB_W-1:0] page_bits_reg;
    logic [GS_W-1:0] group_size_reg;
    logic            result_valid_reg;
    merge_word_t     result_reg;
    track_ctrl_t     ctrl;
    logic            last;
    logic            accept;
    merge_word_t     decision;

    assign cfg_ready  = 1'b1;
    assign item_ready = !(last && result_valid_reg && !result_ready);
    assign accept     = item_valid && item_ready;

    assign ctrl.advance    = accept;
    assign ctrl.page_bits  = page_bits_reg;
    assign ctrl.group_size = group_size_reg;

    lbmc_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .page     (item),
        .last     (last),
        .decision (decision)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bits_reg  <= PAGE_BITS_RESET;
            group_size_reg <= GROUP_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PAGE_BITS:  page_bits_reg  <= cfg_data[PB_W-1:0];
                REG_GROUP_SIZE: group_size_reg <= cfg_data[GS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept && last)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
            result_reg <= decision;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[hw/rtl/lbmc_track.sv]
// Per-block page tracker: running flags, counts and the merge decision.
module lbmc_track
    import lbmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  track_ctrl_t ctrl,
    input  page_word_t  page,
    output logic        last,
    output merge_word_t decision
);

    logic [MAX_PAGE_BITS-1:0] page_index_reg, page_index_next;
    logic [CNT_W-1:0]         valid_count_reg, valid_count_next;
    logic [CNT_W-1:0]         prefix_count_reg, prefix_count_next;
    logic [LPN_BITS-1:0]      first_lblock_reg, first_lblock_next;
    logic                     first_present_reg, first_present_next;
    logic [PROD_W-1:0]        group_base_reg, group_base_next;
    logic [GS_W-1:0]          group_size_reg, group_size_next;
    logic                     switch_ok_reg, switch_ok_next;
    logic                     reorder_ok_reg, reorder_ok_next;
    logic                     partial_ok_reg, partial_ok_next;
    logic                     free_seen_reg, free_seen_next;

    logic [PB_W-1:0]          pb;
    logic [GS_W-1:0]          gs;
    logic [MAX_PAGE_BITS-1:0] off_mask;
    logic [LPN_BITS-1:0]      lb_here;
    logic [LPN_BITS-1:0]      lblock_cur;
    logic                     first_page;
    logic                     is_valid, is_free, in_block, in_place;
    logic [LPN_BITS-1:0]      base_diff;
    logic                     first_ok;

    // Clamp the page bits and group size into their working ranges.
    always_comb
    begin
        if (ctrl.page_bits == '0)
            pb = PB_W'(1);
        else if (ctrl.page_bits > PB_W'(MAX_PAGE_BITS))
            pb = PB_W'(MAX_PAGE_BITS);
        else
            pb = ctrl.page_bits;
        gs = (ctrl.group_size == '0) ? GS_W'(1) : ctrl.group_size;
    end

    assign off_mask   = {MAX_PAGE_BITS{1'b1}} >> (PB_W'(MAX_PAGE_BITS) - pb);
    assign lb_here    = page.page_lpn >> pb;
    assign first_page = (page_index_reg == '0);
    assign last       = (page_index_reg >= off_mask);

    // The first page fixes the logical block the rest are matched against.
    assign lblock_cur = first_page ? (page.lpn_present ? lb_here : '0) : first_lblock_reg;

    assign is_valid = (page.page_state == PS_LIVE);
    assign is_free  = (page.page_state == PS_EMPTY);
    assign in_block = page.lpn_present && (lb_here == lblock_cur);
    assign in_place = in_block
                   && ((page.page_lpn[MAX_PAGE_BITS-1:0] & off_mask) == page_index_reg);

    // Group membership: base <= lblock < base + group size, with base = gid * size.
    // The product is registered at the first page; the block always has two or more.
    assign base_diff = first_lblock_reg - LPN_BITS'(group_base_reg);
    assign first_ok  = first_present_reg
                    && (first_lblock_reg >= LPN_BITS'(group_base_reg))
                    && (base_diff < LPN_BITS'(group_size_reg));

    // Next state of the running flags and counts.
    always_comb
    begin
        first_lblock_next  = lblock_cur;
        first_present_next = first_page ? page.lpn_present : first_present_reg;
        group_base_next    = first_page ? (PROD_W'(page.group_id) * PROD_W'(gs))
                                        : group_base_reg;
        group_size_next    = first_page ? gs : group_size_reg;
        valid_count_next   = valid_count_reg + CNT_W'(is_valid);
        switch_ok_next     = switch_ok_reg && is_valid && in_place;
        reorder_ok_next    = reorder_ok_reg && is_valid && in_block;
        free_seen_next     = free_seen_reg;
        prefix_count_next  = prefix_count_reg;
        partial_ok_next    = partial_ok_reg;
        if (!free_seen_reg)
        begin
            if (is_free)
                free_seen_next = 1'b1;
            else
            begin
                prefix_count_next = prefix_count_reg + CNT_W'(1);
                partial_ok_next   = partial_ok_reg && is_valid && in_place;
            end
        end
        page_index_next = page_index_reg + MAX_PAGE_BITS'(1);
    end

    // Merge decision in priority order, from the state after this page.
    always_comb
    begin
        decision.merge_lblock = first_lblock_reg;
        decision.valid_pages  = valid_count_next;
        decision.prefix_pages = prefix_count_next;
        if (valid_count_next == '0)
            decision.merge_kind = KIND_ERASE;
        else if (first_ok && switch_ok_next)
            decision.merge_kind = KIND_SWITCH;
        else if (first_ok && reorder_ok_next)
            decision.merge_kind = KIND_REORDER;
        else if (first_ok && partial_ok_next)
            decision.merge_kind = KIND_PARTIAL;
        else
            decision.merge_kind = KIND_FULL;
    end

    // Block state; it clears after the last page of each block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_index_reg    <= '0;
            valid_count_reg   <= '0;
            prefix_count_reg  <= '0;
            first_lblock_reg  <= '0;
            first_present_reg <= 1'b0;
            group_base_reg    <= '0;
            group_size_reg    <= GS_W'(1);
            switch_ok_reg     <= 1'b1;
            reorder_ok_reg    <= 1'b1;
            partial_ok_reg    <= 1'b1;
            free_seen_reg     <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            if (last)
            begin
                page_index_reg    <= '0;
                valid_count_reg   <= '0;
                prefix_count_reg  <= '0;
                first_lblock_reg  <= '0;
                first_present_reg <= 1'b0;
                switch_ok_reg     <= 1'b1;
                reorder_ok_reg    <= 1'b1;
                partial_ok_reg    <= 1'b1;
                free_seen_reg     <= 1'b0;
            end
            else
            begin
                page_index_reg    <= page_index_next;
                valid_count_reg   <= valid_count_next;
                prefix_count_reg  <= prefix_count_next;
                first_lblock_reg  <= first_lblock_next;
                first_present_reg <= first_present_next;
                group_base_reg    <= group_base_next;
                group_size_reg    <= group_size_next;
                switch_ok_reg     <= switch_ok_next;
                reorder_ok_reg    <= reorder_ok_next;
                partial_ok_reg    <= partial_ok_next;
                free_seen_reg     <= free_seen_next;
            end
        end
    end

endmodule

[sim/lbmc_decision_checker.sv]
// Checker that tracks the page words of each log block, predicts its merge decision and compares.
module lbmc_decision_checker
    import lbmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  page_word_t            item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  merge_word_t           result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    logic [PB_W-1:0]     cur_page_bits;
    logic [GS_W-1:0]     cur_group_size;

    // Running view of the block being classified.
    int unsigned         page_no;
    int unsigned         valid_seen;
    int unsigned         prefix_seen;
    logic [LPN_BITS-1:0] block_lblock;
    bit                  group_match;
    bit                  all_in_place;
    bit                  all_in_block;
    bit                  prefix_in_place;
    bit                  free_hit;

    // Decisions predicted but not yet seen on the result channel.
    merge_word_t         decisions_due[$];
    merge_word_t         want;

    // Prints one line per mismatch and counts it.
    task automatic report_error(input string msg);
        $display("%0t ns  ERROR: %s", $time, msg);
        error_count++;
    endtask

    task automatic clear_tracking();
        page_no         = 0;
        valid_seen      = 0;
        prefix_seen     = 0;
        block_lblock    = '0;
        group_match     = 1'b0;
        all_in_place    = 1'b1;
        all_in_block    = 1'b1;
        prefix_in_place = 1'b1;
        free_hit        = 1'b0;
    endtask

    // Folds one accepted page word into the block view; the last page yields a decision.
    task automatic track_page(input page_word_t w);
        int unsigned       eff_bits;
        longint unsigned   span;
        longint unsigned   lb_here;
        longint unsigned   gs;
        bit                is_valid;
        bit                is_free;
        bit                in_block;
        bit                in_place;
        merge_word_t       d;

        // Out-of-range page_bits values are clamped into 1..MAX_PAGE_BITS.
        eff_bits = cur_page_bits;
        if (eff_bits < 1)
            eff_bits = 1;
        if (eff_bits > MAX_PAGE_BITS)
            eff_bits = MAX_PAGE_BITS;
        span    = 64'd1 << eff_bits;
        lb_here = w.page_lpn >> eff_bits;

        // The first page fixes the logical block and the group check.
        if (page_no == 0)
        begin
            gs           = (cur_group_size == 0) ? 64'd1 : cur_group_size;
            block_lblock = w.lpn_present ? lb_here[LPN_BITS-1:0] : '0;
            group_match  = w.lpn_present && ((block_lblock / gs) == w.group_id);
        end

        is_valid = (w.page_state == PS_LIVE);
        is_free  = (w.page_state == PS_EMPTY);
        in_block = w.lpn_present && (lb_here == block_lblock);
        in_place = in_block && ((w.page_lpn & (span - 1)) == page_no);

        if (is_valid)
            valid_seen++;
        if (!(is_valid && in_place))
            all_in_place = 1'b0;
        if (!(is_valid && in_block))
            all_in_block = 1'b0;

        // Prefix runs up to the first free page.
        if (!free_hit)
        begin
            if (is_free)
                free_hit = 1'b1;
            else
            begin
                prefix_seen++;
                if (!(is_valid && in_place))
                    prefix_in_place = 1'b0;
            end
        end

        if (page_no < span - 1)
        begin
            page_no++;
        end
        else
        begin
            if (valid_seen == 0)
                d.merge_kind = KIND_ERASE;
            else if (group_match && all_in_place)
                d.merge_kind = KIND_SWITCH;
            else if (group_match && all_in_block)
                d.merge_kind = KIND_REORDER;
            else if (group_match && prefix_in_place)
                d.merge_kind = KIND_PARTIAL;
            else
                d.merge_kind = KIND_FULL;
            d.merge_lblock = block_lblock;
            d.valid_pages  = CNT_W'(valid_seen);
            d.prefix_pages = CNT_W'(prefix_seen);
            decisions_due.push_back(d);
            clear_tracking();
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_page_bits  = PAGE_BITS_RESET;
            cur_group_size = GROUP_SIZE_RESET;
            clear_tracking();
            decisions_due.delete();
            pending     = 0;
            error_count = 0;
        end
        else
        begin
            // A decision word leaving this edge belongs to an earlier block.
            if (result_valid && result_ready)
            begin
                if (decisions_due.size() == 0)
                begin
                    report_error("merge decision word with no decision pending");
                end
                else
                begin
                    want = decisions_due.pop_front();
                    if (result.merge_kind !== want.merge_kind)
                        report_error($sformatf("merge_kind %0d, expected %0d",
                                               result.merge_kind, want.merge_kind));
                    if (result.merge_lblock !== want.merge_lblock)
                        report_error($sformatf("merge_lblock %0h, expected %0h",
                                               result.merge_lblock, want.merge_lblock));
                    if (result.valid_pages !== want.valid_pages)
                        report_error($sformatf("valid_pages %0d, expected %0d",
                                               result.valid_pages, want.valid_pages));
                    if (result.prefix_pages !== want.prefix_pages)
                        report_error($sformatf("prefix_pages %0d, expected %0d",
                                               result.prefix_pages, want.prefix_pages));
                end
            end

            if (item_valid && item_ready)
                track_page(item);

            // Register writes take effect after the page of the same edge.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PAGE_BITS)
                    cur_page_bits = cfg_data[PB_W-1:0];
                else
                    cur_group_size = cfg_data[GS_W-1:0];
            end

            pending = decisions_due.size();
        end
    end

endmodule

[sim/log_block_merge_classifier_unit_test.sv]
// Top of the merge classifier testbench: clock, reset, page and register stimulus, verdict.
module log_block_merge_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lbmc_pkg::*;

    // Shapes of generated log blocks.
    typedef enum int {
        SHAPE_ERASE,
        SHAPE_SWITCH,
        SHAPE_REORDER,
        SHAPE_PARTIAL,
        SHAPE_NOISE
    } block_shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    page_word_t            item;
    logic                  result_valid;
    logic                  result_ready;
    merge_word_t           result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    error_count;
    int                    pending;
    logic                  item_taken;
    logic                  cfg_taken;
    bit                    calm;
    int                    order[1024];
    int                    k;

    log_block_merge_classifier_unit dut (
        .clk,
        .rst_n,
        .item_valid,
        .item_ready,
        .item,
        .result_valid,
        .result_ready,
        .result,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    lbmc_decision_checker checker_i (
        .clk,
        .rst_n,
        .item_valid,
        .item_ready,
        .item,
        .result_valid,
        .result_ready,
        .result,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data,
        .error_count,
        .pending
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Remember whether a word was taken at the last rising edge.
    always @(posedge clk)
    begin
        item_taken <= item_valid && item_ready;
        cfg_taken  <= cfg_valid && cfg_ready;
    end

    // Result side stalls at random unless the run is in a calm stretch.
    always @(negedge clk)
    begin
        result_ready <= calm || ($urandom_range(99) >= 18);
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 18);
    endfunction

    function automatic page_word_t mk_page(input page_state_t st, input logic present,
                                           input logic [LPN_BITS-1:0] lpn,
                                           input logic [GID_W-1:0] gid);
        page_word_t w;
        w.page_state  = st;
        w.lpn_present = present;
        w.page_lpn    = lpn;
        w.group_id    = gid;
        return w;
    endfunction

    // Any page at all; half of the numbers land inside the given logical block.
    function automatic page_word_t random_page(input longint unsigned lb, input int bits);
        page_word_t w;
        w.page_state  = 2'($urandom_range(3));
        w.lpn_present = 1'($urandom_range(1));
        if ($urandom_range(1) == 0)
            w.page_lpn = $urandom;
        else
            w.page_lpn = LPN_BITS'((lb << bits) | $urandom_range((1 << bits) - 1));
        w.group_id = GID_W'($urandom);
        return w;
    endfunction

    // Offers one page word, possibly after a gap, and returns once it is taken.
    task automatic send_page(input page_word_t w);
        while (take_break())
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do @(negedge clk); while (!item_taken);
    endtask

    // Writes page_bits and then group_size with valid held high across both words.
    task automatic configure(input int pb, input int gs);
        cfg_valid <= 1'b1;
        cfg_index <= REG_PAGE_BITS;
        cfg_data  <= CFG_DATA_W'(pb);
        do @(negedge clk); while (!cfg_taken);
        cfg_index <= REG_GROUP_SIZE;
        cfg_data  <= CFG_DATA_W'(gs);
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering pages and waits for every predicted decision, plus a short settle.
    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Sends whole blocks: mostly well-formed merge candidates, some broken, some noise.
    task automatic run_blocks(input int pb_raw, input int gs_raw, input int count);
        int              bits;
        int              gsz;
        int              span;
        int              cut;
        int              spoil;
        int              j;
        int              tmp;
        int              pick;
        block_shape_t    shape;
        longint unsigned top_lb;
        longint unsigned max_gid;
        longint unsigned gid;
        longint unsigned lb;
        page_word_t      w;

        bits    = (pb_raw < 1) ? 1 : ((pb_raw > MAX_PAGE_BITS) ? MAX_PAGE_BITS : pb_raw);
        gsz     = (gs_raw == 0) ? 1 : gs_raw;
        span    = 1 << bits;
        top_lb  = (64'd1 << (LPN_BITS - bits)) - 1;
        max_gid = top_lb / gsz;
        if (max_gid > 65535)
            max_gid = 65535;

        repeat (count)
        begin
            pick = $urandom_range(9);
            case (pick)
                0:       shape = SHAPE_ERASE;
                1, 2, 3: shape = SHAPE_SWITCH;
                4, 5:    shape = SHAPE_REORDER;
                6, 7:    shape = SHAPE_PARTIAL;
                default: shape = SHAPE_NOISE;
            endcase

            // Pick a group and a logical block inside it; now and then a wrong group.
            gid = $urandom_range(max_gid);
            lb  = gid * gsz + $urandom_range(gsz - 1);
            if (lb > top_lb)
                lb = top_lb;
            if ($urandom_range(7) == 0)
                gid = gid ^ (64'd1 << $urandom_range(15));

            // Page offsets, shuffled for a reorder candidate.
            for (j = 0; j < span; j++)
                order[j] = j;
            if (shape == SHAPE_REORDER)
            begin
                for (j = span - 1; j > 0; j--)
                begin
                    pick       = $urandom_range(j);
                    tmp        = order[j];
                    order[j]   = order[pick];
                    order[pick] = tmp;
                end
            end

            cut   = $urandom_range(span - 1);
            spoil = ($urandom_range(5) == 0) ? int'($urandom_range(span - 1)) : -1;

            for (j = 0; j < span; j++)
            begin
                w = mk_page(PS_LIVE, 1'b1, LPN_BITS'((lb << bits) | order[j]),
                            GID_W'(gid));
                case (shape)
                    SHAPE_ERASE:
                    begin
                        w = random_page(lb, bits);
                        if (w.page_state == PS_LIVE)
                            w.page_state = PS_STALE;
                    end
                    SHAPE_PARTIAL:
                    begin
                        if (j == cut)
                            w.page_state = PS_EMPTY;
                        else if (j > cut)
                            w = random_page(lb, bits);
                    end
                    SHAPE_NOISE:
                        w = random_page(lb, bits);
                    default:
                        ;
                endcase
                if (j == spoil)
                    w = random_page(lb, bits);
                send_page(w);
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_PAGE_BITS;
        cfg_data     = '0;
        calm         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One block at the register reset values.
        run_blocks(int'(PAGE_BITS_RESET), int'(GROUP_SIZE_RESET), 1);
        drain();

        // Directed blocks of four pages; group 5 of size 3 holds logical block 16.
        configure(2, 3);

        // Nothing valid, extreme field values and the unused state code.
        send_page(mk_page(PS_EMPTY, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        send_page(mk_page(PS_STALE, 1'b0, 32'h0, 16'h0));
        send_page(mk_page(PS_RESERVED, 1'b1, 32'h0, 16'hFFFF));
        send_page(mk_page(PS_EMPTY, 1'b0, 32'hFFFF_FFFF, 16'h0));

        // Every page in place; a changed group id on a later page does not count.
        for (k = 0; k < 4; k++)
            send_page(mk_page(PS_LIVE, 1'b1, 64 + k, (k == 3) ? 16'hFFFF : 16'd5));

        // Every page in the block but out of order.
        send_page(mk_page(PS_LIVE, 1'b1, 66, 16'd5));
        send_page(mk_page(PS_LIVE, 1'b1, 64, 16'd5));
        send_page(mk_page(PS_LIVE, 1'b1, 67, 16'd5));
        send_page(mk_page(PS_LIVE, 1'b1, 65, 16'd5));

        // In-place prefix ending at a free page.
        send_page(mk_page(PS_LIVE, 1'b1, 64, 16'd5));
        send_page(mk_page(PS_LIVE, 1'b1, 65, 16'd5));
        send_page(mk_page(PS_EMPTY, 1'b0, 66, 16'd5));
        send_page(mk_page(PS_LIVE, 1'b1, 32'hDEAD_BEEF, 16'd5));

        // First page carries no number, so only a full merge is possible.
        send_page(mk_page(PS_LIVE, 1'b0, 64, 16'd5));
        for (k = 1; k < 4; k++)
            send_page(mk_page(PS_LIVE, 1'b1, 64 + k, 16'd5));

        // Wrong group, and the largest page number.
        send_page(mk_page(PS_LIVE, 1'b1, 64, 16'd6));
        send_page(mk_page(PS_LIVE, 1'b1, 65, 16'd6));
        send_page(mk_page(PS_LIVE, 1'b1, 66, 16'd6));
        send_page(mk_page(PS_LIVE, 1'b1, 32'hFFFF_FFFF, 16'd6));
        drain();

        // Random blocks over a range of settings, small blocks for most of them.
        configure(1, 1);
        run_blocks(1, 1, 30);
        drain();

        configure(0, 0);
        run_blocks(0, 0, 20);
        drain();

        configure(3, 1024);
        run_blocks(3, 1024, 10);
        drain();

        configure(2, 2047);
        run_blocks(2, 2047, 15);
        drain();

        // A stretch with no gaps on either side.
        calm <= 1'b1;
        configure(1, 2);
        run_blocks(1, 2, 25);
        drain();
        calm <= 1'b0;

        configure(4, 7);
        run_blocks(4, 7, 3);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lbmc_pkg.sv
hw/rtl/lbmc_track.sv
hw/rtl/log_block_merge_classifier_unit.sv
sim/lbmc_decision_checker.sv
sim/log_block_merge_classifier_unit_test.sv
